>>> rtl/lltd_pkg.sv
// ----------------------------------------------------------------------------
// lltd_pkg
// Shared widths, limits, sequencer states and arithmetic unit types for the
// least-loaded task dispatcher.
// ----------------------------------------------------------------------------
package lltd_pkg;

  localparam int LOAD_W     = 24;
  localparam int TIME_W     = 16;
  localparam int MC_W       = 5;
  localparam int MACH_OUT_W = 4;
  localparam int SLOT_OUT_W = 7;
  localparam int TASKNUM_W  = 8;

  localparam int MACHINES_DEF          = 16;
  localparam int TASKS_PER_MACHINE_DEF = 128;

  localparam logic [LOAD_W-1:0]    LOAD_MAX    = '1;
  localparam logic [TASKNUM_W-1:0] TASKNUM_MAX = '1;
  localparam logic [MC_W-1:0]      MC_RESET    = MC_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_READ,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ALU_MIN,
    ALU_MAX,
    ALU_ADD
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [LOAD_W-1:0] a;
    logic [LOAD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              less;
    logic [LOAD_W-1:0] res;
  } alu_rsp_t;

endpackage

>>> rtl/lltd_ram.sv
// ----------------------------------------------------------------------------
// lltd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lltd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/lltd_alu.sv
// ----------------------------------------------------------------------------
// lltd_alu
// Shared compare and saturating add unit: minimum, maximum or load update.
// ----------------------------------------------------------------------------
module lltd_alu import lltd_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [LOAD_W:0] sum;
  logic            less;

  assign sum  = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign less = req_i.a < req_i.b;

  always_comb begin
    rsp_o.less = less;
    unique case (req_i.op)
      ALU_MIN: rsp_o.res = less ? req_i.a : req_i.b;
      ALU_MAX: rsp_o.res = less ? req_i.b : req_i.a;
      ALU_ADD: rsp_o.res = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
      default: rsp_o.res = '0;
    endcase
  end

endmodule

>>> rtl/least_loaded_task_dispatcher.sv
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher
// Greedy list scheduler: each task goes to the least loaded machine, with
// per-machine load and task count kept in a small RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | task_time_i, first_task_i, last_task_i
//  out     | output    | out_valid_o/out_ready_i | assigned_machine_o, slot_index_o,
//          |           |                       | machine_load_o, makespan_o, job_done_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | machine_count_i
//
//  a task in the first round of a job goes straight to the next unused machine;
//  a later task first scans the machines in use for the least load through the
//  RAM read port and the shared compare unit, one machine per cycle
//  reset clears loads and counts at once through per-machine valid bits
//  the next task is taken while a result waits; a stalled output holds the
//  sequencer in its final step
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher import lltd_pkg::*; #(
  parameter int MACHINES          = MACHINES_DEF,
  parameter int TASKS_PER_MACHINE = TASKS_PER_MACHINE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     task_time_i,
  input  logic                  first_task_i,
  input  logic                  last_task_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MACH_OUT_W-1:0] assigned_machine_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [LOAD_W-1:0]     machine_load_o,
  output logic [LOAD_W-1:0]     makespan_o,
  output logic                  job_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [MC_W-1:0]       machine_count_i
);

  localparam int MW  = $clog2(MACHINES);
  localparam int MCW = $clog2(MACHINES + 1);
  localparam int CW  = $clog2(TASKS_PER_MACHINE + 1);
  localparam int SW  = $clog2(TASKS_PER_MACHINE);
  localparam int RW  = CW + LOAD_W;

  state_e state_q, state_d;

  logic [MC_W-1:0]      mc_cfg_q;
  logic [MCW-1:0]       mc;
  logic [MACHINES-1:0]  valid_q;
  logic [TASKNUM_W-1:0] tn_q;
  logic [LOAD_W-1:0]    mks_q;
  logic [MCW-1:0]       scan_q;
  logic                 out_valid_q;
  logic                 out_free;

  logic [TIME_W-1:0]    dur_q;
  logic                 last_q;
  logic [MW-1:0]        pick_q;
  logic [LOAD_W-1:0]    min_q;
  logic [MW-1:0]        rd_addr_q;
  logic [LOAD_W-1:0]    load_q;
  logic [SW-1:0]        slot_q;

  logic                 ram_re;
  logic                 ram_we;
  logic [MW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic [RW-1:0]        ram_wdata;
  logic                 rd_valid;
  logic [LOAD_W-1:0]    rd_load;
  logic [CW-1:0]        rd_count;
  logic [CW-1:0]        count_new;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // clamp machine count to 1..MACHINES
  always_comb begin
    if (32'(mc_cfg_q) > MACHINES) begin
      mc = MCW'(MACHINES);
    end else if (mc_cfg_q == '0) begin
      mc = MCW'(1);
    end else begin
      mc = MCW'(mc_cfg_q);
    end
  end

  // an entry not written since the job started reads as zero
  assign rd_valid  = valid_q[rd_addr_q];
  assign rd_load   = rd_valid ? ram_rdata[LOAD_W-1:0] : '0;
  assign rd_count  = rd_valid ? ram_rdata[RW-1:LOAD_W] : '0;
  assign count_new = (rd_count < CW'(TASKS_PER_MACHINE)) ? rd_count + CW'(1) : rd_count;
  assign ram_wdata = {count_new, alu_rsp.res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    alu_req   = '{op: ALU_MIN, a: rd_load, b: min_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        if (32'(tn_q) < 32'(mc)) begin
          state_d = ST_READ;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        alu_req = '{op: ALU_MIN, a: rd_load, b: min_q};
        if (scan_q == mc) begin
          state_d = ST_READ;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_q[MW-1:0];
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = pick_q;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        alu_req = '{op: ALU_ADD, a: rd_load, b: LOAD_W'(dur_q)};
        ram_we  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        alu_req = '{op: ALU_MAX, a: load_q, b: mks_q};
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_cfg_q    <= MC_RESET;
      valid_q     <= '0;
      tn_q        <= '0;
      mks_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) mc_cfg_q <= machine_count_i;
      if (state_q == ST_IDLE && in_valid_i && first_task_i) begin
        valid_q <= '0;
        tn_q    <= '0;
        mks_q   <= '0;
      end
      if (state_q == ST_START) scan_q <= MCW'(1);
      if (state_q == ST_SCAN && scan_q != mc) scan_q <= scan_q + MCW'(1);
      if (state_q == ST_WAIT) valid_q[pick_q] <= 1'b1;
      if (state_q == ST_FIN && out_free) begin
        mks_q       <= alu_rsp.res;
        out_valid_q <= 1'b1;
        if (tn_q != TASKNUM_MAX) tn_q <= tn_q + TASKNUM_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      dur_q  <= task_time_i;
      last_q <= last_task_i;
    end
    if (ram_re) rd_addr_q <= ram_raddr;
    if (state_q == ST_START) pick_q <= tn_q[MW-1:0];
    if (state_q == ST_SCAN && (rd_addr_q == '0 || alu_rsp.less)) begin
      min_q  <= rd_load;
      pick_q <= rd_addr_q;
    end
    if (state_q == ST_WAIT) begin
      load_q <= alu_rsp.res;
      slot_q <= (rd_count > CW'(TASKS_PER_MACHINE - 1)) ?
                SW'(TASKS_PER_MACHINE - 1) : rd_count[SW-1:0];
    end
    if (state_q == ST_FIN && out_free) begin
      assigned_machine_o <= MACH_OUT_W'(pick_q);
      slot_index_o       <= SLOT_OUT_W'(slot_q);
      machine_load_o     <= load_q;
      makespan_o         <= alu_rsp.res;
      job_done_o         <= last_q;
    end
  end

  lltd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  lltd_ram #(
    .WIDTH (RW),
    .DEPTH (MACHINES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/lltd_checker.sv
// ----------------------------------------------------------------------------
// lltd_checker
// Port-level checks for the least-loaded task dispatcher, bound to the top.
// ----------------------------------------------------------------------------
module lltd_checker import lltd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [TIME_W-1:0]     task_time_i,
  input logic                  first_task_i,
  input logic                  last_task_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [MACH_OUT_W-1:0] assigned_machine_o,
  input logic [SLOT_OUT_W-1:0] slot_index_o,
  input logic [LOAD_W-1:0]     machine_load_o,
  input logic [LOAD_W-1:0]     makespan_o,
  input logic                  job_done_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [MC_W-1:0]       machine_count_i
);

  // a waiting result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(assigned_machine_o)
      && $stable(slot_index_o) && $stable(machine_load_o) && $stable(makespan_o)
      && $stable(job_done_o))
    else $error("output payload changed while stalled");

  // an accepted task keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // makespan covers the load just reported
  a_makespan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> makespan_o >= machine_load_o)
    else $error("makespan below machine load");

  // no result appears from nothing: a new result follows a step of the sequencer
  a_no_new_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_ready_o && !in_valid_i |=> !out_valid_o)
    else $error("result without a task");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

  logic unused_ok;
  assign unused_ok = ^{task_time_i, first_task_i, last_task_i, machine_count_i};

endmodule

bind least_loaded_task_dispatcher lltd_checker u_checker (.*);
